[sv/vhzpr_pkg.sv]
// ----------------------------------------------------------------------------
// vhzpr_pkg: shared types, codes and table functions
// Holds the register indexes, the datapath command codes, the sequencer step
// table and the sine function used to fill the waveform ROM.
// ----------------------------------------------------------------------------
package vhzpr_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;

   // Configuration register indexes.
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_STEP = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RATED      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RPM        = 2'd2;

   localparam logic [30:0] PHASE_STEP_RESET = 31'd25769803;
   localparam logic [14:0] RATED_RESET      = 15'd16384;
   localparam logic [14:0] RPM_RESET        = 15'd1800;

   // One per-unit in Q3.13.
   localparam logic signed [15:0] ONE_PU = 16'sd8192;

   // Multiplier operand A selects.
   localparam logic [2:0] A_NONE  = 3'd0;
   localparam logic [2:0] A_STEP  = 3'd1;
   localparam logic [2:0] A_RATED = 3'd2;
   localparam logic [2:0] A_VS    = 3'd3;
   localparam logic [2:0] A_COS   = 3'd4;
   localparam logic [2:0] A_SIN   = 3'd5;
   localparam logic [2:0] A_RPM   = 3'd6;

   // Multiplier operand B selects.
   localparam logic [2:0] B_REF    = 3'd0;
   localparam logic [2:0] B_ABSREF = 3'd1;
   localparam logic [2:0] B_COS    = 3'd2;
   localparam logic [2:0] B_SIN    = 3'd3;
   localparam logic [2:0] B_IA     = 3'd4;
   localparam logic [2:0] B_IB     = 3'd5;
   localparam logic [2:0] B_VA     = 3'd6;
   localparam logic [2:0] B_VB     = 3'd7;

   // Accumulator operations.
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;
   localparam logic [1:0] ACC_SUB  = 2'd3;

   // Result store targets.
   localparam logic [2:0] ST_NONE = 3'd0;
   localparam logic [2:0] ST_VA   = 3'd1;
   localparam logic [2:0] ST_VB   = 3'd2;
   localparam logic [2:0] ST_ID   = 3'd3;
   localparam logic [2:0] ST_IQ   = 3'd4;
   localparam logic [2:0] ST_VD   = 3'd5;
   localparam logic [2:0] ST_VQ   = 3'd6;
   localparam logic [2:0] ST_RPM  = 3'd7;
   localparam int NUM_RESULTS = 7;

   // Sequencer steps.
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_WAIT = 5'd4;
   localparam logic [STEP_W-1:0] STEP_LAST = 5'd16;

   // Divider iterations (quotient is known to fit in 15 bits).
   localparam int DIV_STEPS = 15;

   typedef struct packed {
      logic       load_in;
      logic [2:0] a_sel;
      logic [2:0] b_sel;
      logic [1:0] acc_op;
      logic [2:0] st_sel;
      logic       phase_upd;
      logic       vs_upd;
      logic       rom_cos;
      logic       cap_sin;
      logic       cap_cos;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

   function automatic cmd_type step_cmd(input logic [STEP_W-1:0] step);
      cmd_type c;
      c = '0;
      case (step)
         5'd0: begin
            c.a_sel = A_STEP; c.b_sel = B_REF; c.acc_op = ACC_LOAD;
         end
         5'd1: begin
            c.phase_upd = 1'b1;
            c.a_sel = A_RATED; c.b_sel = B_ABSREF; c.acc_op = ACC_LOAD;
         end
         5'd2: begin
            c.vs_upd = 1'b1;
         end
         5'd3: begin
            c.rom_cos = 1'b1; c.cap_sin = 1'b1;
         end
         5'd4: begin
            c.cap_cos = 1'b1;
         end
         5'd5: begin
            c.a_sel = A_VS; c.b_sel = B_COS; c.acc_op = ACC_LOAD;
         end
         5'd6: begin
            c.st_sel = ST_VA;
            c.a_sel = A_VS; c.b_sel = B_SIN; c.acc_op = ACC_LOAD;
         end
         5'd7: begin
            c.st_sel = ST_VB;
            c.a_sel = A_COS; c.b_sel = B_IA; c.acc_op = ACC_LOAD;
         end
         5'd8: begin
            c.a_sel = A_SIN; c.b_sel = B_IB; c.acc_op = ACC_ADD;
         end
         5'd9: begin
            c.st_sel = ST_ID;
            c.a_sel = A_COS; c.b_sel = B_IB; c.acc_op = ACC_LOAD;
         end
         5'd10: begin
            c.a_sel = A_SIN; c.b_sel = B_IA; c.acc_op = ACC_SUB;
         end
         5'd11: begin
            c.st_sel = ST_IQ;
            c.a_sel = A_COS; c.b_sel = B_VA; c.acc_op = ACC_LOAD;
         end
         5'd12: begin
            c.a_sel = A_SIN; c.b_sel = B_VB; c.acc_op = ACC_ADD;
         end
         5'd13: begin
            c.st_sel = ST_VD;
            c.a_sel = A_COS; c.b_sel = B_VB; c.acc_op = ACC_LOAD;
         end
         5'd14: begin
            c.a_sel = A_SIN; c.b_sel = B_VA; c.acc_op = ACC_SUB;
         end
         5'd15: begin
            c.st_sel = ST_VQ;
            c.a_sel = A_RPM; c.b_sel = B_REF; c.acc_op = ACC_LOAD;
         end
         5'd16: begin
            c.st_sel = ST_RPM;
         end
         default: begin
            c = '0;
         end
      endcase
      return c;
   endfunction

   // Sine over a quarter turn, angle in Q30 quarter-turn units, Q15 result.
   function automatic logic [15:0] quarter_sine(input longint unsigned a);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned r;
      x  = (a * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824 - x2 / 64'd72;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
      r  = (((x * t) >> 30) + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[15:0];
   endfunction

   // Sine over a full turn, 2^32 per turn.
   function automatic logic signed [15:0] turn_sine(input logic [31:0] ang);
      longint unsigned a;
      logic [15:0]     v;
      a = {34'd0, ang[29:0]};
      if (ang[30]) begin
         a = 64'd1073741824 - a;
      end
      v = quarter_sine(a);
      return ang[31] ? -$signed(v) : $signed(v);
   endfunction

endpackage

[sv/volts_per_hertz_park_rotator.sv]
// ----------------------------------------------------------------------------
// volts_per_hertz_park_rotator: V/f phase generator with Park transform
// Advances the phase by the per-unit speed, builds the V/f voltage command
// and rotates the measured currents and voltages into the phase frame.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Width  Contents
//   req_     in         80     speed reference and stationary-frame samples
//   rsp_     out        128    voltage command, d/q quantities, rpm, phase
//   csr_     in         31     write-only register port, index 0 to 2
//
// Items with speed_ref above 1.0 per-unit also wait for the restoring
// divider that computes the falling magnitude. All products go one at a
// time through a single 32 x 18 multiplier with an accumulator.
// Reset is synchronous: registers return to their defaults, the phase to zero.
// A finished result waits in the output register while the next item is
// taken; the sequencer stalls only if a second result is ready before the
// first has been transferred.
//
module volts_per_hertz_park_rotator #(
   parameter int SINE_TABLE_DEPTH = vhzpr_pkg::SINE_TABLE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // speed_ref, current_alpha, current_beta, voltage_alpha, voltage_beta
   input  logic [79:0]                       req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // voltage_cmd_alpha, voltage_cmd_beta, current_d, current_q, voltage_d,
   // voltage_q, speed_rpm, phase_out
   output logic [127:0]                      rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [vhzpr_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [30:0]                       csr_wdata
);

   // Commands from the sequencer and status back from the datapath.
   vhzpr_pkg::cmd_type    cmd;
   vhzpr_pkg::status_type status;

   vhzpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath owns the phase accumulator, the configuration registers,
   // the waveform ROM (sine and cosine read in turn), the divider and the
   // output register.
   vhzpr_dp #(
      .DEPTH (SINE_TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_data  (req_tdata),
      .rsp_data  (rsp_tdata)
   );

endmodule

[sv/vhzpr_rom.sv]
// ----------------------------------------------------------------------------
// vhzpr_rom: sine waveform ROM
// One full turn of sine in Q1.15, filled at elaboration, registered read.
// ----------------------------------------------------------------------------
module vhzpr_rom #(
   parameter int DEPTH = vhzpr_pkg::SINE_TABLE_DEPTH
) (
   input  logic                       clock,
   input  logic [$clog2(DEPTH)-1:0]   addr,
   output logic signed [15:0]         rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int SH = 32 - AW;

   typedef logic signed [15:0] tab_type [DEPTH];

   function automatic tab_type build_tab();
      tab_type t;
      for (int k = 0; k < DEPTH; k++) begin
         t[k] = vhzpr_pkg::turn_sine(32'(k) << SH);
      end
      return t;
   endfunction

   localparam tab_type TAB = build_tab();

   logic signed [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= TAB[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/vhzpr_div.sv]
// ----------------------------------------------------------------------------
// vhzpr_div: restoring divider for the field-weakening magnitude
// Computes (rated * 8192) / den for den above 8192, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module vhzpr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [14:0] rated,
   input  logic [14:0] den,
   output logic        busy,
   output logic [14:0] quotient
);

   localparam logic [3:0] LAST_CNT = 4'(vhzpr_pkg::DIV_STEPS - 1);

   logic [14:0] rem_ff;
   logic [14:0] dvd_ff;
   logic [14:0] quo_ff;
   logic [14:0] den_ff;
   logic [3:0]  cnt_ff;
   logic        busy_ff;

   logic [15:0] trial;
   logic [15:0] diff;
   logic        ge;

   // The quotient fits 15 bits, so the upper 13 dividend bits alone stay
   // below the divisor and seed the remainder directly.
   assign trial = {rem_ff, dvd_ff[14]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 4'd1;
         if (cnt_ff == LAST_CNT) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {2'b00, rated[14:2]};
         dvd_ff <= {rated[1:0], 13'd0};
         quo_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[14:0] : trial[14:0];
         dvd_ff <= {dvd_ff[13:0], 1'b0};
         quo_ff <= {quo_ff[13:0], ge};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[sv/vhzpr_dp.sv]
// ----------------------------------------------------------------------------
// vhzpr_dp: datapath of the rotator
// Configuration registers, phase accumulator, shared multiplier and
// accumulator, waveform ROM, divider and result registers.
// ----------------------------------------------------------------------------
module vhzpr_dp #(
   parameter int DEPTH = vhzpr_pkg::SINE_TABLE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  vhzpr_pkg::cmd_type                cmd,
   output vhzpr_pkg::status_type             status,
   input  logic                              csr_we,
   input  logic [vhzpr_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [30:0]                       csr_wdata,
   input  logic [79:0]                       req_data,
   output logic [127:0]                      rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] QUARTER = AW'(DEPTH / 4);
   localparam int NUM_RES = vhzpr_pkg::NUM_RESULTS;

   logic [30:0]        step_ff;
   logic [14:0]        rated_ff;
   logic [14:0]        rpm_ff;
   logic [31:0]        phase_ff;
   logic signed [15:0] ref_ff;
   logic signed [15:0] ia_ff;
   logic signed [15:0] ib_ff;
   logic signed [15:0] va_ff;
   logic signed [15:0] vb_ff;
   logic signed [49:0] acc_ff;
   logic signed [49:0] acc_in;
   logic signed [15:0] sin_ff;
   logic signed [15:0] cos_ff;
   logic [16:0]        vs_ff;
   logic               need_div_ff;
   logic signed [15:0] res_ff [NUM_RES];
   logic [127:0]       out_ff;

   logic signed [16:0] ref_ext;
   logic [16:0]        abs_ref;
   logic [16:0]        vs_src;
   logic signed [31:0] a_val;
   logic signed [17:0] b_val;
   logic signed [49:0] prod;
   logic signed [49:0] shifted;
   logic signed [15:0] sat_val;
   logic [AW-1:0]      rom_addr;
   logic signed [15:0] rom_q;
   logic               div_start;
   logic               div_busy;
   logic [14:0]        div_q;

   assign ref_ext = {ref_ff[15], ref_ff};
   assign abs_ref = ref_ff[15] ? 17'(-ref_ext) : 17'(ref_ext);
   assign vs_src  = need_div_ff ? {2'b00, div_q} : vs_ff;

   always_comb begin
      case (cmd.a_sel)
         vhzpr_pkg::A_STEP:  a_val = $signed({1'b0, step_ff});
         vhzpr_pkg::A_RATED: a_val = $signed({17'd0, rated_ff});
         vhzpr_pkg::A_VS:    a_val = $signed({15'd0, vs_src});
         vhzpr_pkg::A_COS:   a_val = 32'(cos_ff);
         vhzpr_pkg::A_SIN:   a_val = 32'(sin_ff);
         vhzpr_pkg::A_RPM:   a_val = $signed({17'd0, rpm_ff});
         default:            a_val = '0;
      endcase
   end

   always_comb begin
      case (cmd.b_sel)
         vhzpr_pkg::B_REF:    b_val = 18'(ref_ff);
         vhzpr_pkg::B_ABSREF: b_val = $signed({1'b0, abs_ref});
         vhzpr_pkg::B_COS:    b_val = 18'(cos_ff);
         vhzpr_pkg::B_SIN:    b_val = 18'(sin_ff);
         vhzpr_pkg::B_IA:     b_val = 18'(ia_ff);
         vhzpr_pkg::B_IB:     b_val = 18'(ib_ff);
         vhzpr_pkg::B_VA:     b_val = 18'(va_ff);
         vhzpr_pkg::B_VB:     b_val = 18'(vb_ff);
         default:             b_val = '0;
      endcase
   end

   assign prod = a_val * b_val;

   always_comb begin
      case (cmd.acc_op)
         vhzpr_pkg::ACC_LOAD: acc_in = prod;
         vhzpr_pkg::ACC_ADD:  acc_in = acc_ff + prod;
         vhzpr_pkg::ACC_SUB:  acc_in = acc_ff - prod;
         default:             acc_in = acc_ff;
      endcase
   end

   // Floor shift and saturation of the accumulator into a 16-bit result.
   always_comb begin
      shifted = (cmd.st_sel == vhzpr_pkg::ST_RPM) ? (acc_ff >>> 13) : (acc_ff >>> 15);
      if (shifted > 50'sd32767) begin
         sat_val = 16'sh7fff;
      end else if (shifted < -50'sd32768) begin
         sat_val = 16'sh8000;
      end else begin
         sat_val = shifted[15:0];
      end
   end

   assign rom_addr  = phase_ff[31 -: AW] + (cmd.rom_cos ? QUARTER : AW'(0));
   assign div_start = cmd.vs_upd && (ref_ff > vhzpr_pkg::ONE_PU);

   vhzpr_rom #(
      .DEPTH (DEPTH)
   ) u_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .rd_data (rom_q)
   );

   vhzpr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rated    (rated_ff),
      .den      (ref_ff[14:0]),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign status.div_busy = div_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= vhzpr_pkg::PHASE_STEP_RESET;
         rated_ff <= vhzpr_pkg::RATED_RESET;
         rpm_ff   <= vhzpr_pkg::RPM_RESET;
         phase_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               vhzpr_pkg::CSR_PHASE_STEP: step_ff  <= csr_wdata;
               vhzpr_pkg::CSR_RATED:      rated_ff <= csr_wdata[14:0];
               vhzpr_pkg::CSR_RPM:        rpm_ff   <= csr_wdata[14:0];
               default: ;
            endcase
         end
         if (cmd.phase_upd) begin
            phase_ff <= phase_ff + acc_ff[44:13];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         ref_ff <= req_data[15:0];
         ia_ff  <= req_data[31:16];
         ib_ff  <= req_data[47:32];
         va_ff  <= req_data[63:48];
         vb_ff  <= req_data[79:64];
      end
      acc_ff <= acc_in;
      if (cmd.vs_upd) begin
         vs_ff       <= acc_ff[29:13];
         need_div_ff <= ref_ff > vhzpr_pkg::ONE_PU;
      end
      if (cmd.cap_sin) begin
         sin_ff <= rom_q;
      end
      if (cmd.cap_cos) begin
         cos_ff <= rom_q;
      end
      for (int i = 0; i < NUM_RES; i++) begin
         if (cmd.st_sel == 3'(i + 1)) begin
            res_ff[i] <= sat_val;
         end
      end
      if (cmd.load_out) begin
         out_ff <= {phase_ff[31:16], res_ff[6], res_ff[5], res_ff[4], res_ff[3],
                    res_ff[2], res_ff[1], res_ff[0]};
      end
   end

   assign rsp_data = out_ff;

endmodule

[sv/vhzpr_ctrl.sv]
// ----------------------------------------------------------------------------
// vhzpr_ctrl: sequencer of the rotator
// Steps the datapath through one item, waits for the divider, and hands the
// finished result to the output register.
// ----------------------------------------------------------------------------
module vhzpr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  vhzpr_pkg::status_type  status,
   output vhzpr_pkg::cmd_type     cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]                   state_ff;
   logic [1:0]                   state_in;
   logic [vhzpr_pkg::STEP_W-1:0] step_ff;
   logic [vhzpr_pkg::STEP_W-1:0] step_in;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic                         slot_free;

   assign slot_free = !out_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_RUN;
               step_in     = '0;
            end
         end
         S_RUN: begin
            cmd     = vhzpr_pkg::step_cmd(step_ff);
            step_in = step_ff + vhzpr_pkg::STEP_W'(1);
            if (step_ff == vhzpr_pkg::STEP_WAIT) begin
               state_in = S_WAIT;
            end else if (step_ff == vhzpr_pkg::STEP_LAST) begin
               state_in = S_DONE;
            end
         end
         S_WAIT: begin
            if (!status.div_busy) begin
               state_in = S_RUN;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

[sv/vhzpr_checker.sv]
// ----------------------------------------------------------------------------
// vhzpr_checker: port-level checks of the rotator
// Watches the stream handshakes over time and is bound to the top level.
// ----------------------------------------------------------------------------
module vhzpr_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its data.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result data changed while stalled");

   // Reset leaves the block idle and empty.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   // An accepted item keeps the block busy in the following cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again while an item is in work");

endmodule

bind volts_per_hertz_park_rotator vhzpr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the V/f phase rotator with Park transform
// Drives speed references and stationary-frame samples through the request
// stream and checks every response against a predictor of the phase
// accumulator, V/f magnitude, Park rotation and rpm scaling.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int TABLE_DEPTH = 1024;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic signed [15:0] voltage_beta;
      logic signed [15:0] voltage_alpha;
      logic signed [15:0] current_beta;
      logic signed [15:0] current_alpha;
      logic signed [15:0] speed_ref;
   } sample_type;

   typedef struct packed {
      logic [15:0]        phase_out;
      logic signed [15:0] speed_rpm;
      logic signed [15:0] voltage_q;
      logic signed [15:0] voltage_d;
      logic signed [15:0] current_q;
      logic signed [15:0] current_d;
      logic signed [15:0] voltage_cmd_beta;
      logic signed [15:0] voltage_cmd_alpha;
   } rotor_frame_type;

   // One row of the directed table. When has_golden is set the typed-in
   // response is checked against the predictor as well.
   typedef struct {
      sample_type      stim;
      logic            has_golden;
      rotor_frame_type golden;
   } directed_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic [79:0]   req_tdata = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  rsp_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic          csr_we = 1'b0;
   logic [vhzpr_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [30:0]   csr_wdata = '0;

   // Predictor state: its own copy of the phase and the register values.
   logic [31:0]   angle_acc;
   logic [30:0]   step_per_unit;
   logic [14:0]   rated_code;
   logic [14:0]   rpm_scale;
   int            sine_rom [TABLE_DEPTH];
   int            cosine_rom [TABLE_DEPTH];

   rotor_frame_type pending_frames[$];
   int            error_count = 0;
   longint        cycle_count = 0;
   bit            stim_done = 1'b0;
   bit            monitor_run = 1'b1;

   volts_per_hertz_park_rotator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: a stuck handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Quarter-wave sine in Q30 angle units, evaluated as an odd polynomial.
   function automatic int qsin(longint unsigned a);
      longint unsigned x, x2, t, r;
      x  = (a * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824 - x2 / 72;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
      r  = (((x * t) >> 30) + 64'd16384) >> 15;
      if (r > 32767) r = 32767;
      return int'(r);
   endfunction

   function automatic int full_sin(logic [31:0] ang);
      longint unsigned a;
      int v;
      a = ang[29:0];
      if (ang[30]) a = 64'd1073741824 - a;
      v = qsin(a);
      return ang[31] ? -v : v;
   endfunction

   // Arithmetic shift right floors, which is what the block does.
   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic rotor_frame_type rotate_sample(sample_type s);
      rotor_frame_type f;
      longint ref_v, delta, mag, sn, cs;
      longint ia, ib, va, vb;
      int idx;
      ref_v = s.speed_ref;
      ia = s.current_alpha;
      ib = s.current_beta;
      va = s.voltage_alpha;
      vb = s.voltage_beta;
      delta = (longint'(step_per_unit) * ref_v) >>> 13;
      angle_acc = angle_acc + delta[31:0];
      idx = angle_acc[31:22];
      sn = sine_rom[idx];
      cs = cosine_rom[idx];
      if (ref_v > 8192) mag = (longint'(rated_code) * 8192) / ref_v;
      else mag = ((ref_v < 0) ? -ref_v : ref_v) * longint'(rated_code) >>> 13;
      f.voltage_cmd_alpha = clamp16((mag * cs) >>> 15);
      f.voltage_cmd_beta  = clamp16((mag * sn) >>> 15);
      f.current_d = clamp16((cs * ia + sn * ib) >>> 15);
      f.current_q = clamp16((cs * ib - sn * ia) >>> 15);
      f.voltage_d = clamp16((cs * va + sn * vb) >>> 15);
      f.voltage_q = clamp16((cs * vb - sn * va) >>> 15);
      f.speed_rpm = clamp16((longint'(rpm_scale) * ref_v) >>> 13);
      f.phase_out = angle_acc[31:16];
      return f;
   endfunction

   // Block must be idle here; the predictor mirrors the write and masking.
   // The enable drops between writes so that writes never share a time step.
   task automatic write_csr(logic [vhzpr_pkg::CSR_ADDR_W-1:0] idx, logic [30:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         vhzpr_pkg::CSR_PHASE_STEP: step_per_unit = val;
         vhzpr_pkg::CSR_RATED:      rated_code = val[14:0];
         vhzpr_pkg::CSR_RPM:        rpm_scale = val[14:0];
         default: ;
      endcase
   endtask

   // Sender gaps: mostly none or short, now and then long. Valid drops only
   // when there is a real gap, so back-to-back items keep it high.
   task automatic sender_gap();
      int n;
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) n = 0;
      else if (pick < 92) n = $urandom_range(3, 1);
      else n = $urandom_range(60, 10);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_sample(sample_type s);
      pending_frames.push_back(rotate_sample(s));
      req_tdata  <= s;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic sample_type random_sample(int style);
      sample_type s;
      s = $urandom;
      s.current_alpha = $urandom;
      s.current_beta  = $urandom;
      s.voltage_alpha = $urandom;
      s.voltage_beta  = $urandom;
      // Most speeds stay in the working range, some cover the full code span.
      if (style < 60) s.speed_ref = $urandom_range(16384) - 8192;
      else if (style < 80) s.speed_ref = $urandom_range(24576, 8193);
      else s.speed_ref = $urandom;
      return s;
   endfunction

   // Response side: random backpressure and the field-by-field compare.
   initial begin
      rotor_frame_type got, want;
      int pick;
      while (monitor_run) begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_frames.size() == 0) begin
               $error("response with no sample outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               want = pending_frames.pop_front();
               if (got.voltage_cmd_alpha !== want.voltage_cmd_alpha) begin
                  $error("voltage_cmd_alpha exp %0d got %0d",
                         want.voltage_cmd_alpha, got.voltage_cmd_alpha);
                  error_count++;
               end
               if (got.voltage_cmd_beta !== want.voltage_cmd_beta) begin
                  $error("voltage_cmd_beta exp %0d got %0d",
                         want.voltage_cmd_beta, got.voltage_cmd_beta);
                  error_count++;
               end
               if (got.current_d !== want.current_d) begin
                  $error("current_d exp %0d got %0d", want.current_d, got.current_d);
                  error_count++;
               end
               if (got.current_q !== want.current_q) begin
                  $error("current_q exp %0d got %0d", want.current_q, got.current_q);
                  error_count++;
               end
               if (got.voltage_d !== want.voltage_d) begin
                  $error("voltage_d exp %0d got %0d", want.voltage_d, got.voltage_d);
                  error_count++;
               end
               if (got.voltage_q !== want.voltage_q) begin
                  $error("voltage_q exp %0d got %0d", want.voltage_q, got.voltage_q);
                  error_count++;
               end
               if (got.speed_rpm !== want.speed_rpm) begin
                  $error("speed_rpm exp %0d got %0d", want.speed_rpm, got.speed_rpm);
                  error_count++;
               end
               if (got.phase_out !== want.phase_out) begin
                  $error("phase_out exp %0d got %0d", want.phase_out, got.phase_out);
                  error_count++;
               end
            end
         end
         // During quiet stretches the receiver is always ready.
         pick = $urandom_range(99);
         if (stim_done || (cycle_count % 4000) < 600) rsp_tready <= 1'b1;
         else if (pick < 70) rsp_tready <= 1'b1;
         else if (pick < 97) rsp_tready <= 1'b0;
         else rsp_tready <= ($urandom_range(9) == 0);
      end
   end

   initial begin
      directed_row_type rows[$];
      directed_row_type row;
      rotor_frame_type  seen;
      sample_type       s;
      int               k, phase_no, style;
      logic [31:0]      ang;

      for (k = 0; k < TABLE_DEPTH; k++) begin
         ang = k << 22;
         sine_rom[k]   = full_sin(ang);
         cosine_rom[k] = full_sin(ang + 32'h4000_0000);
      end
      angle_acc     = '0;
      step_per_unit = vhzpr_pkg::PHASE_STEP_RESET;
      rated_code    = vhzpr_pkg::RATED_RESET;
      rpm_scale     = vhzpr_pkg::RPM_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. The first row uses reset settings at zero phase:
      // zero speed leaves sine at zero and cosine at 32767, so the rotation
      // passes the currents through one code low after the floor shift.
      row.has_golden = 1'b1;
      row.stim = '{16'sd0, 16'sd0, 16'sd300, 16'sd100, 16'sd0};
      row.golden = '{16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd299, 16'sd99, 16'sd0, 16'sd0};
      rows.push_back(row);
      row.has_golden = 1'b0;
      row.stim = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sd8192};
      rows.push_back(row);  // exactly one per-unit
      row.stim = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sd8193};
      rows.push_back(row);  // just above one per-unit, magnitude starts falling
      row.stim = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
      rows.push_back(row);  // highest speed
      row.stim = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      rows.push_back(row);  // most negative speed: magnitude over rated
      row.stim = '{16'sd1, -16'sd1, 16'sd1, -16'sd1, -16'sd8192};
      rows.push_back(row);  // reverse rotation wraps the phase
      row.stim = '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1};
      rows.push_back(row);
      row.stim = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
      rows.push_back(row);
      row.stim = '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555};
      rows.push_back(row);
      row.stim = '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa};
      rows.push_back(row);

      foreach (rows[i]) begin
         if (rows[i].has_golden) begin
            seen = rotate_sample(rows[i].stim);
            angle_acc = '0;
            if (seen !== rows[i].golden) begin
               $error("predictor disagrees with typed-in row %0d", i);
               error_count++;
            end
         end
         send_sample(rows[i].stim);
         sender_gap();
      end
      drain();

      // Register extremes, including a zero rated voltage.
      write_csr(vhzpr_pkg::CSR_RATED, 31'h0);
      write_csr(vhzpr_pkg::CSR_RPM, 31'h7fff);
      write_csr(vhzpr_pkg::CSR_PHASE_STEP, 31'h7fff_ffff);
      for (k = 0; k < 6; k++) begin
         s = random_sample(k * 20);
         send_sample(s);
      end
      drain();

      // Random phases, each with its own register setting.
      for (phase_no = 0; phase_no < 6; phase_no++) begin
         case (phase_no)
            0: begin
               write_csr(vhzpr_pkg::CSR_PHASE_STEP, vhzpr_pkg::PHASE_STEP_RESET);
               write_csr(vhzpr_pkg::CSR_RATED, 31'h7fff);
               write_csr(vhzpr_pkg::CSR_RPM, 31'h0);
            end
            1: begin
               write_csr(vhzpr_pkg::CSR_PHASE_STEP, 31'h0);
               write_csr(vhzpr_pkg::CSR_RATED, 31'(vhzpr_pkg::RATED_RESET));
               write_csr(vhzpr_pkg::CSR_RPM, 31'(vhzpr_pkg::RPM_RESET));
            end
            // Upper bits beyond the 15-bit registers are dropped.
            2: begin
               write_csr(vhzpr_pkg::CSR_RATED, 31'h7fff_ffff);
               write_csr(vhzpr_pkg::CSR_RPM, 31'h5555_0123);
            end
            default: begin
               write_csr(vhzpr_pkg::CSR_PHASE_STEP, 31'($urandom));
               write_csr(vhzpr_pkg::CSR_RATED, 31'($urandom));
               write_csr(vhzpr_pkg::CSR_RPM, 31'($urandom));
            end
         endcase
         for (k = 0; k < 255; k++) begin
            style = $urandom_range(99);
            send_sample(random_sample(style));
            if (!((phase_no == 3) && (k < 120))) sender_gap();
         end
         drain();
      end

      stim_done = 1'b1;
      drain();
      monitor_run = 1'b0;
      if (pending_frames.size() != 0) begin
         $error("%0d responses never arrived", pending_frames.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
